### sv/pap_pkg.sv
// ----------------------------------------------------------------------------
// pap_pkg - polygon measure shared definitions
// Widths, multiplier operand codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package pap_pkg;

  localparam int COORD_BITS      = 16;
  localparam int PERIM_FRAC_BITS = 8;
  localparam int MAX_VERTICES    = 4096;

  localparam int OPND_W  = COORD_BITS + 1;
  localparam int PROD_W  = 2 * OPND_W;
  localparam int RAD_W   = 2 * COORD_BITS + 2;
  localparam int CROSS_W = 2 * COORD_BITS + 12;
  localparam int AREA_W  = 34;
  localparam int PERIM_W = 37;
  localparam int COUNT_W = 13;

  localparam int ROOT_STEPS = RAD_W / 2 + PERIM_FRAC_BITS;
  localparam int ROOT_W     = ROOT_STEPS;
  localparam int REM_W      = ROOT_W + 2;
  localparam int STEP_CNT_W = $clog2(ROOT_STEPS + 1);

  localparam logic [1:0] MUL_AXBY = 2'd0;
  localparam logic [1:0] MUL_AYBX = 2'd1;
  localparam logic [1:0] MUL_DXDX = 2'd2;
  localparam logic [1:0] MUL_DYDY = 2'd3;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       close;
    logic       root_start;
    logic       perim_add;
    logic       emit;
  } pap_cmd_t;

  typedef struct packed {
    logic in_poly;
    logic last;
    logic root_busy;
  } pap_stat_t;

endpackage

### sv/pap_sqrt.sv
// ----------------------------------------------------------------------------
// pap_sqrt - iterative integer square root
// Digit-by-digit root of a radicand scaled by 4^PERIM_FRAC_BITS, one bit of
// root per cycle, truncated.
// ----------------------------------------------------------------------------
module pap_sqrt
  import pap_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [RAD_W-1:0]  rad,
  output logic              busy,
  output logic [ROOT_W-1:0] root
);

  logic                  busy_r, busy_nxt;
  logic [STEP_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [RAD_W-1:0]      rad_r, rad_nxt;
  logic [REM_W-1:0]      rem_r, rem_nxt;
  logic [ROOT_W-1:0]     root_r, root_nxt;
  logic [REM_W-1:0]      rem_t;
  logic [REM_W-1:0]      trial;

  assign rem_t = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
  assign trial = {root_r, 2'b01};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = STEP_CNT_W'(ROOT_STEPS);
      rad_nxt  = rad;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      rad_nxt = {rad_r[RAD_W-3:0], 2'b00};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == STEP_CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
      if (rem_t >= trial) begin
        rem_nxt  = rem_t - trial;
        root_nxt = {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_t;
        root_nxt = {root_r[ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

### sv/pap_dp.sv
// ----------------------------------------------------------------------------
// pap_dp - polygon measure datapath
// Vertex registers, shared multiplier, cross and perimeter sums, box, count
// and the result registers.
// ----------------------------------------------------------------------------
module pap_dp
  import pap_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  pap_cmd_t                     cmd,
  output pap_stat_t                    stat,
  input  logic signed [COORD_BITS-1:0] in_vx,
  input  logic signed [COORD_BITS-1:0] in_vy,
  input  logic                         in_last_vertex,
  output logic [AREA_W-1:0]            out_twice_area,
  output logic [PERIM_W-1:0]           out_perimeter_q8,
  output logic signed [COORD_BITS-1:0] out_box_min_x,
  output logic signed [COORD_BITS-1:0] out_box_max_x,
  output logic signed [COORD_BITS-1:0] out_box_min_y,
  output logic signed [COORD_BITS-1:0] out_box_max_y,
  output logic [COUNT_W-1:0]           out_vertex_total,
  output logic                         out_too_many
);

  logic                         in_poly_r;
  logic                         last_r;
  logic signed [COORD_BITS-1:0] cur_x_r, cur_y_r, first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic signed [COORD_BITS-1:0] min_x_r, max_x_r, min_y_r, max_y_r;
  logic [COUNT_W-1:0]           count_r;
  logic                         over_r;
  logic [CROSS_W-1:0]           cross_r;
  logic [RAD_W-1:0]             rad_r;
  logic [PERIM_W-1:0]           perim_r;
  logic signed [PROD_W-1:0]     prod_r;
  logic                         prod_vld_r;
  logic [1:0]                   prod_sel_r;

  logic [AREA_W-1:0]            area_o_r;
  logic [PERIM_W-1:0]           perim_o_r;
  logic signed [COORD_BITS-1:0] min_x_o_r, max_x_o_r, min_y_o_r, max_y_o_r;
  logic [COUNT_W-1:0]           count_o_r;
  logic                         over_o_r;

  logic signed [OPND_W-1:0]     ax, ay, bx, by, dx, dy, opa, opb;
  logic [CROSS_W-1:0]           prod_ext;
  logic [ROOT_W-1:0]            root;
  logic                         root_busy;
  logic [PERIM_W:0]             perim_sum;
  logic [CROSS_W-1:0]           area_mag;
  logic [AREA_W-1:0]            area_sat;

  assign ax = cmd.close ? OPND_W'(cur_x_r) : OPND_W'(prev_x_r);
  assign ay = cmd.close ? OPND_W'(cur_y_r) : OPND_W'(prev_y_r);
  assign bx = cmd.close ? OPND_W'(first_x_r) : OPND_W'(cur_x_r);
  assign by = cmd.close ? OPND_W'(first_y_r) : OPND_W'(cur_y_r);
  assign dx = bx - ax;
  assign dy = by - ay;

  always_comb begin
    case (cmd.mul_sel)
      MUL_AXBY: begin
        opa = ax;
        opb = by;
      end
      MUL_AYBX: begin
        opa = ay;
        opb = bx;
      end
      MUL_DXDX: begin
        opa = dx;
        opb = dx;
      end
      default: begin
        opa = dy;
        opb = dy;
      end
    endcase
  end

  assign prod_ext  = CROSS_W'(prod_r);
  assign perim_sum = {1'b0, perim_r} + (PERIM_W + 1)'(root);
  assign area_mag  = cross_r[CROSS_W-1] ? (~cross_r + 1'b1) : cross_r;
  assign area_sat  = (|area_mag[CROSS_W-1:AREA_W]) ? '1 : area_mag[AREA_W-1:0];

  pap_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.root_start),
    .rad   (rad_r),
    .busy  (root_busy),
    .root  (root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_poly_r  <= 1'b0;
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= cmd.mul_en;
      if (cmd.load) begin
        in_poly_r <= 1'b1;
      end else if (cmd.emit) begin
        in_poly_r <= 1'b0;
      end
    end

    if (cmd.mul_en) begin
      prod_r     <= opa * opb;
      prod_sel_r <= cmd.mul_sel;
    end

    if (cmd.load) begin
      cur_x_r <= in_vx;
      cur_y_r <= in_vy;
      last_r  <= in_last_vertex;
      if (!in_poly_r) begin
        first_x_r <= in_vx;
        first_y_r <= in_vy;
        prev_x_r  <= in_vx;
        prev_y_r  <= in_vy;
        min_x_r   <= in_vx;
        max_x_r   <= in_vx;
        min_y_r   <= in_vy;
        max_y_r   <= in_vy;
        cross_r   <= '0;
        perim_r   <= '0;
        count_r   <= COUNT_W'(1);
        over_r    <= 1'b0;
      end else begin
        if (in_vx < min_x_r) min_x_r <= in_vx;
        if (in_vx > max_x_r) max_x_r <= in_vx;
        if (in_vy < min_y_r) min_y_r <= in_vy;
        if (in_vy > max_y_r) max_y_r <= in_vy;
        if (count_r < COUNT_W'(MAX_VERTICES)) begin
          count_r <= count_r + 1'b1;
        end else begin
          over_r <= 1'b1;
        end
      end
    end

    if (prod_vld_r) begin
      case (prod_sel_r)
        MUL_AXBY: cross_r <= cross_r + prod_ext;
        MUL_AYBX: cross_r <= cross_r - prod_ext;
        MUL_DXDX: rad_r   <= RAD_W'(prod_r);
        default:  rad_r   <= rad_r + RAD_W'(prod_r);
      endcase
    end

    if (cmd.perim_add) begin
      perim_r  <= perim_sum[PERIM_W] ? '1 : perim_sum[PERIM_W-1:0];
      prev_x_r <= cur_x_r;
      prev_y_r <= cur_y_r;
    end

    if (cmd.emit) begin
      area_o_r  <= area_sat;
      perim_o_r <= perim_r;
      min_x_o_r <= min_x_r;
      max_x_o_r <= max_x_r;
      min_y_o_r <= min_y_r;
      max_y_o_r <= max_y_r;
      count_o_r <= count_r;
      over_o_r  <= over_r;
    end
  end

  assign stat.in_poly   = in_poly_r;
  assign stat.last      = last_r;
  assign stat.root_busy = root_busy;

  assign out_twice_area   = area_o_r;
  assign out_perimeter_q8 = perim_o_r;
  assign out_box_min_x    = min_x_o_r;
  assign out_box_max_x    = max_x_o_r;
  assign out_box_min_y    = min_y_o_r;
  assign out_box_max_y    = max_y_o_r;
  assign out_vertex_total = count_o_r;
  assign out_too_many     = over_o_r;

endmodule

### sv/pap_ctrl.sv
// ----------------------------------------------------------------------------
// pap_ctrl - polygon measure controller
// Sequences each edge through the multiplier, the root unit and the
// perimeter add, and runs both handshakes.
// ----------------------------------------------------------------------------
module pap_ctrl
  import pap_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      in_last_vertex,
  output logic      out_valid,
  input  logic      out_ready,
  output pap_cmd_t  cmd,
  input  pap_stat_t stat
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_M0   = 4'd1;
  localparam logic [3:0] S_M1   = 4'd2;
  localparam logic [3:0] S_M2   = 4'd3;
  localparam logic [3:0] S_M3   = 4'd4;
  localparam logic [3:0] S_M4   = 4'd5;
  localparam logic [3:0] S_RS   = 4'd6;
  localparam logic [3:0] S_RT   = 4'd7;
  localparam logic [3:0] S_ADD  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       close_r, close_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt      = state_r;
    close_nxt      = close_r;
    cmd            = '0;
    cmd.close      = close_r;
    in_ready       = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (stat.in_poly) begin
            state_nxt = S_M0;
            close_nxt = 1'b0;
          end else if (in_last_vertex) begin
            state_nxt = S_M0;
            close_nxt = 1'b1;
          end
        end
      end
      S_M0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_AXBY;
        state_nxt   = S_M1;
      end
      S_M1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_AYBX;
        state_nxt   = S_M2;
      end
      S_M2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_DXDX;
        state_nxt   = S_M3;
      end
      S_M3: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_DYDY;
        state_nxt   = S_M4;
      end
      S_M4: begin
        state_nxt = S_RS;
      end
      S_RS: begin
        cmd.root_start = 1'b1;
        state_nxt      = S_RT;
      end
      S_RT: begin
        if (!stat.root_busy) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        cmd.perim_add = 1'b1;
        if (close_r) begin
          state_nxt = S_OUT;
        end else if (stat.last) begin
          state_nxt = S_M0;
          close_nxt = 1'b1;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      close_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      close_r     <= close_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### sv/polygon_area_perimeter_bbox.sv
// ----------------------------------------------------------------------------
// polygon_area_perimeter_bbox - closed polygon area, perimeter and box
// Vertices arrive one item each; the item flagged last closes the polygon
// and yields one result: twice the area, perimeter (8 fraction bits), box,
// vertex count and overflow flag.
// ----------------------------------------------------------------------------
// Sequence: an opening vertex is just registered. Every further vertex costs
// one edge, and the last vertex also the closing edge. An edge runs four
// products on the single shared multiplier, then the 25-step bit-serial
// square root, then the perimeter add; no vertex is taken while it runs. A
// lone vertex (opening and last at once) costs the closing edge alone. A
// closing vertex also waits while an earlier result is untaken. The result
// sits in an output register, so the next polygon is accepted while it waits.
module polygon_area_perimeter_bbox
  import pap_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_vx,
  input  logic signed [COORD_BITS-1:0] in_vy,
  input  logic                         in_last_vertex,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [AREA_W-1:0]            out_twice_area,
  output logic [PERIM_W-1:0]           out_perimeter_q8,
  output logic signed [COORD_BITS-1:0] out_box_min_x,
  output logic signed [COORD_BITS-1:0] out_box_max_x,
  output logic signed [COORD_BITS-1:0] out_box_min_y,
  output logic signed [COORD_BITS-1:0] out_box_max_y,
  output logic [COUNT_W-1:0]           out_vertex_total,
  output logic                         out_too_many
);

  pap_cmd_t  cmd;
  pap_stat_t stat;

  pap_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_last_vertex (in_last_vertex),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .cmd            (cmd),
    .stat           (stat)
  );

  pap_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_vx            (in_vx),
    .in_vy            (in_vy),
    .in_last_vertex   (in_last_vertex),
    .out_twice_area   (out_twice_area),
    .out_perimeter_q8 (out_perimeter_q8),
    .out_box_min_x    (out_box_min_x),
    .out_box_max_x    (out_box_max_x),
    .out_box_min_y    (out_box_min_y),
    .out_box_max_y    (out_box_max_y),
    .out_vertex_total (out_vertex_total),
    .out_too_many     (out_too_many)
  );

endmodule

### sim/polygon_area_perimeter_bbox_test.sv
// ----------------------------------------------------------------------------
// polygon_area_perimeter_bbox_test - self-checking bench for the polygon unit
// Vertices are sent over the input handshake. A built-in predictor keeps its
// own shoelace sum, perimeter, box and count, and queues one expected result
// per closed polygon. Every result taken is checked field by field. Runs
// directed extremes, random traffic under three idling mixes, a long output
// stall and area saturation.
// ----------------------------------------------------------------------------
module polygon_area_perimeter_bbox_test;
  import pap_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam logic [43:0] AREA_CAP  = (44'd1 << AREA_W) - 44'd1;
  localparam logic [63:0] PERIM_CAP = (64'd1 << PERIM_W) - 64'd1;

  typedef struct {
    logic [AREA_W-1:0]            twice_area;
    logic [PERIM_W-1:0]           perimeter_q8;
    logic signed [COORD_BITS-1:0] min_x;
    logic signed [COORD_BITS-1:0] max_x;
    logic signed [COORD_BITS-1:0] min_y;
    logic signed [COORD_BITS-1:0] max_y;
    logic [COUNT_W-1:0]           vertex_total;
    logic                         too_many;
  } polygon_result_t;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic signed [COORD_BITS-1:0] in_vx;
  logic signed [COORD_BITS-1:0] in_vy;
  logic                         in_last_vertex;
  logic                         out_valid;
  logic                         out_ready;
  logic [AREA_W-1:0]            out_twice_area;
  logic [PERIM_W-1:0]           out_perimeter_q8;
  logic signed [COORD_BITS-1:0] out_box_min_x;
  logic signed [COORD_BITS-1:0] out_box_max_x;
  logic signed [COORD_BITS-1:0] out_box_min_y;
  logic signed [COORD_BITS-1:0] out_box_max_y;
  logic [COUNT_W-1:0]           out_vertex_total;
  logic                         out_too_many;

  // predictor state
  logic                         poly_open;
  logic signed [COORD_BITS-1:0] anchor_x, anchor_y, tail_x, tail_y;
  logic [CROSS_W-1:0]           shoelace_acc;
  logic [63:0]                  perim_acc;
  logic signed [COORD_BITS-1:0] bb_min_x, bb_max_x, bb_min_y, bb_max_y;
  int                           vert_count;
  logic                         over_limit;

  polygon_result_t polygons_due[$];

  int send_idle_pct;
  int recv_idle_pct;
  int hold_request;
  int hold_left;
  int mismatch_count;
  int polygons_checked;
  int vertices_sent;
  int quiet_cycles;

  polygon_area_perimeter_bbox dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_vx            (in_vx),
    .in_vy            (in_vy),
    .in_last_vertex   (in_last_vertex),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_twice_area   (out_twice_area),
    .out_perimeter_q8 (out_perimeter_q8),
    .out_box_min_x    (out_box_min_x),
    .out_box_max_x    (out_box_max_x),
    .out_box_min_y    (out_box_min_y),
    .out_box_max_y    (out_box_max_y),
    .out_vertex_total (out_vertex_total),
    .out_too_many     (out_too_many)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // digit-by-digit root of the squared edge, scaled by 4^frac
  function automatic logic [63:0] seg_length_q8(input logic [63:0] radicand);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] trial;
    logic [1:0]  pair;
    rem  = '0;
    root = '0;
    for (int i = 0; i < 32 + PERIM_FRAC_BITS; i++) begin
      pair  = (i < 32) ? radicand[2*(31-i) +: 2] : 2'b00;
      rem   = (rem << 2) | pair;
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  task automatic accumulate_side(input logic signed [COORD_BITS-1:0] ax, ay, bx, by);
    longint term;
    longint dx;
    longint dy;
    term = longint'(ax) * longint'(by) - longint'(ay) * longint'(bx);
    dx   = longint'(bx) - longint'(ax);
    dy   = longint'(by) - longint'(ay);
    shoelace_acc = shoelace_acc + term[CROSS_W-1:0];
    perim_acc    = perim_acc + seg_length_q8(64'(dx * dx + dy * dy));
    if (perim_acc > PERIM_CAP) perim_acc = PERIM_CAP;
  endtask

  task automatic predict_vertex(input logic signed [COORD_BITS-1:0] x, y, input logic last);
    polygon_result_t r;
    logic [CROSS_W-1:0] mag;
    if (!poly_open) begin
      anchor_x = x;  anchor_y = y;
      bb_min_x = x;  bb_max_x = x;
      bb_min_y = y;  bb_max_y = y;
      shoelace_acc = '0;
      perim_acc    = '0;
      vert_count   = 1;
      over_limit   = 1'b0;
      poly_open    = 1'b1;
    end else begin
      accumulate_side(tail_x, tail_y, x, y);
      if (x < bb_min_x) bb_min_x = x;
      if (x > bb_max_x) bb_max_x = x;
      if (y < bb_min_y) bb_min_y = y;
      if (y > bb_max_y) bb_max_y = y;
      if (vert_count < MAX_VERTICES) vert_count++;
      else over_limit = 1'b1;
    end
    tail_x = x;
    tail_y = y;
    if (last) begin
      accumulate_side(x, y, anchor_x, anchor_y);
      mag = shoelace_acc[CROSS_W-1] ? (~shoelace_acc + 1'b1) : shoelace_acc;
      if (mag > AREA_CAP) mag = AREA_CAP;
      r.twice_area   = mag[AREA_W-1:0];
      r.perimeter_q8 = perim_acc[PERIM_W-1:0];
      r.min_x        = bb_min_x;
      r.max_x        = bb_max_x;
      r.min_y        = bb_min_y;
      r.max_y        = bb_max_y;
      r.vertex_total = vert_count[COUNT_W-1:0];
      r.too_many     = over_limit;
      polygons_due   = {polygons_due, r};
      poly_open = 1'b0;
    end
  endtask

  task automatic send_vertex(input logic signed [COORD_BITS-1:0] x, y, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_vx          <= x;
    in_vy          <= y;
    in_last_vertex <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_vertex(x, y, last);
    vertices_sent++;
  endtask

  function automatic logic signed [COORD_BITS-1:0] pick_coord(input int style);
    int k;
    k = $urandom_range(9);
    if (style == 0) return COORD_BITS'($urandom_range(40)) - 16'sd20;
    if (style == 1 && k < 3) return (k == 0) ? 16'sh8000 : 16'sh7fff;
    return COORD_BITS'($urandom);
  endfunction

  task automatic check_field(input string name, input logic [63:0] want, got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    polygon_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (polygons_due.size() == 0) begin
        $error("result with no polygon outstanding");
        mismatch_count++;
      end else begin
        want = polygons_due.pop_front();
        check_field("twice_area", 64'(want.twice_area), 64'(out_twice_area));
        check_field("perimeter_q8", 64'(want.perimeter_q8), 64'(out_perimeter_q8));
        check_field("box_min_x", 64'(unsigned'(want.min_x)), 64'(unsigned'(out_box_min_x)));
        check_field("box_max_x", 64'(unsigned'(want.max_x)), 64'(unsigned'(out_box_max_x)));
        check_field("box_min_y", 64'(unsigned'(want.min_y)), 64'(unsigned'(out_box_min_y)));
        check_field("box_max_y", 64'(unsigned'(want.max_y)), 64'(unsigned'(out_box_max_y)));
        check_field("vertex_total", 64'(want.vertex_total), 64'(out_vertex_total));
        check_field("too_many", 64'(want.too_many), 64'(out_too_many));
        polygons_checked++;
      end
    end
  end

  // receiver: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_directed_extremes();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // lone vertex
    send_vertex(16'sh8000, 16'sh7fff, 1'b1);
    // degenerate two-vertex polygon across the full range
    send_vertex(16'sh7fff, 16'sh8000, 1'b0);
    send_vertex(16'sh8000, 16'sh7fff, 1'b1);
    // repeated vertex, zero-length sides
    send_vertex(16'sd5, 16'sd5, 1'b0);
    send_vertex(16'sd5, 16'sd5, 1'b1);
    // clockwise triangle, negative cross sum
    send_vertex(16'sh8000, 16'sh8000, 1'b0);
    send_vertex(16'sh7fff, 16'sh7fff, 1'b0);
    send_vertex(16'sh7fff, 16'sh8000, 1'b1);
    // full square once
    send_vertex(16'sh8000, 16'sh8000, 1'b0);
    send_vertex(16'sh7fff, 16'sh8000, 1'b0);
    send_vertex(16'sh7fff, 16'sh7fff, 1'b0);
    send_vertex(16'sh8000, 16'sh7fff, 1'b1);
    // square wound three times: area saturates
    for (int i = 0; i < 12; i++) begin
      case (i % 4)
        0: send_vertex(16'sh8000, 16'sh8000, 1'b0);
        1: send_vertex(16'sh7fff, 16'sh8000, 1'b0);
        2: send_vertex(16'sh7fff, 16'sh7fff, 1'b0);
        default: send_vertex(16'sh8000, 16'sh7fff, i == 11);
      endcase
    end
  endtask

  task automatic test_random_traffic(input int send_pct, recv_pct, budget);
    int sent;
    int n;
    int style;
    sent = 0;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    while (sent < budget) begin
      n     = ($urandom_range(99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 40);
      style = $urandom_range(2);
      for (int i = 0; i < n; i++)
        send_vertex(pick_coord(style), pick_coord(style), i == n - 1);
      sent += n;
    end
  endtask

  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = 3000;
    for (int p = 0; p < 4; p++)
      for (int i = 0; i < 3; i++)
        send_vertex(pick_coord(2), pick_coord(2), i == 2);
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_vx          <= '0;
    in_vy          <= '0;
    in_last_vertex <= 1'b0;
    poly_open        = 1'b0;
    send_idle_pct    = 0;
    recv_idle_pct    = 0;
    hold_request     = 0;
    hold_left        = 0;
    mismatch_count   = 0;
    polygons_checked = 0;
    vertices_sent    = 0;
    quiet_cycles     = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_extremes();
    test_random_traffic(19, 88, 450);
    test_random_traffic(88, 19, 450);
    test_random_traffic(0, 0, 450);
    test_output_backpressure();

    in_valid <= 1'b0;
    while (polygons_due.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);

    $display("Checked %0d polygons from %0d vertices under mixed stalls.",
             polygons_checked, vertices_sent);
    $display("Included lone vertex, zero-length sides, area saturation and a long hold.");
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
